>>> rtl/core/ccp_pkg.sv
// ----------------------------------------------------------------------------
// ccp_pkg
// Shared types and constants of the chained chunk pool: pool geometry,
// operation and status codes, register indexes and channel item layouts.
// ----------------------------------------------------------------------------
package ccp_pkg;

    // pool geometry
    localparam int NUM_CHUNKS  = 32;
    localparam int CHUNK_BYTES = 64;

    // derived widths
    localparam int CIDX_W  = $clog2(NUM_CHUNKS);
    localparam int CLEN_W  = $clog2(NUM_CHUNKS + 1);
    localparam int OFS_W   = (CHUNK_BYTES > 1) ? $clog2(CHUNK_BYTES) : 1;
    localparam int FILL_W  = $clog2(CHUNK_BYTES + 1);
    localparam int BADDR_W = CIDX_W + OFS_W;
    localparam int BYTE_DEPTH = NUM_CHUNKS * (1 << OFS_W);
    localparam int TOT_W   = (CLEN_W + FILL_W > 13) ? CLEN_W + FILL_W : 13;

    // fixed field widths
    localparam int KIND_W   = 3;
    localparam int HEAD_W   = 5;
    localparam int SIZE_W   = 12;
    localparam int OFF_W    = 11;
    localparam int DATA_W   = 8;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 12;
    localparam int CCOUNT_W = 6;
    localparam int CBYTES_W = 7;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    // operation codes
    typedef enum logic [KIND_W-1:0] {
        KIND_ALLOC  = 3'd0,
        KIND_RESIZE = 3'd1,
        KIND_FREE   = 3'd2,
        KIND_APPEND = 3'd3,
        KIND_WRITE  = 3'd4,
        KIND_READ   = 3'd5
    } t_kind;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NOFREE = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CHUNK_COUNT = 2'd0,
        REG_CHUNK_BYTES = 2'd1
    } t_reg_idx;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [HEAD_W-1:0] head;
        logic [SIZE_W-1:0] size_bytes;
        logic [OFF_W-1:0]  byte_offset;
        logic [DATA_W-1:0] data_byte;
        logic              grow;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [HEAD_W-1:0]   chain_head;
        logic [DATA_W-1:0]   read_byte;
        logic [CNT_W-1:0]    total_bytes;
        logic [CNT_W-1:0]    filled_bytes;
    } t_out_item;

endpackage

>>> rtl/core/ccp_ifs.sv
// ----------------------------------------------------------------------------
// ccp channel interfaces
// Valid/ready channels for operation items, result items and register writes.
// ----------------------------------------------------------------------------
interface ccp_in_if;
    logic              valid;
    logic              ready;
    ccp_pkg::t_in_item item;
    modport source (output valid, item, input ready);
    modport sink   (input valid, item, output ready);
endinterface

interface ccp_out_if;
    logic               valid;
    logic               ready;
    ccp_pkg::t_out_item item;
    modport source (output valid, item, input ready);
    modport sink   (input valid, item, output ready);
endinterface

interface ccp_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ccp_pkg::CFG_IDX_W-1:0]    reg_index;
    logic [ccp_pkg::CFG_DATA_W-1:0]   wdata;
    modport source (output valid, reg_index, wdata, input ready);
    modport sink   (input valid, reg_index, wdata, output ready);
endinterface

>>> rtl/core/chained_chunk_pool.sv
// ----------------------------------------------------------------------------
// chained_chunk_pool
// Buffer manager for a pool of equal chunks joined into linked chains.
// A chain walk steps through S_WALK and S_WWAIT for each chunk (one link memory read
// each), run before the operation and again for the result totals; free scans step
// through the chunks below chunk_count: a count and a claim pass for allocate
// and resize, one claim pass per chunk grown by append or write.
// One item at a time; the next item is taken only after the result is taken.
// Reset clears all chunk marks and fill counts at once; no clearing pass.
// ----------------------------------------------------------------------------
module chained_chunk_pool (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccp_in_if.sink     i_in,
    ccp_out_if.source  o_out,
    ccp_cfg_if.sink    i_cfg
);
    import ccp_pkg::*;

    typedef enum logic [12:0] {
        S_IDLE   = 13'b0000000000001,
        S_CHECK  = 13'b0000000000010,
        S_CLAIM  = 13'b0000000000100,
        S_WALK   = 13'b0000000001000,
        S_WWAIT  = 13'b0000000010000,
        S_WDONE  = 13'b0000000100000,
        S_TRIM   = 13'b0000001000000,
        S_FINDF  = 13'b0000010000000,
        S_APWR   = 13'b0000100000000,
        S_WRSTEP = 13'b0001000000000,
        S_RDSTEP = 13'b0010000000000,
        S_RDWAIT = 13'b0100000000000,
        S_SUM    = 13'b1000000000000
    } t_state;

    // control and chunk state
    t_state                  r_state, n_state;
    logic                    r_out_valid, n_out_valid;
    logic [CCOUNT_W-1:0]     r_cfg_count;
    logic [CBYTES_W-1:0]     r_cfg_bytes;
    logic [NUM_CHUNKS-1:0]   r_in_use, n_in_use;
    logic [NUM_CHUNKS-1:0]   r_has_succ, n_has_succ;
    logic [FILL_W-1:0]       r_fill [NUM_CHUNKS];
    logic [FILL_W-1:0]       n_fill [NUM_CHUNKS];
    logic [CIDX_W-1:0]       r_pred [NUM_CHUNKS];
    logic [CIDX_W-1:0]       n_pred [NUM_CHUNKS];

    // walked chain list and working registers
    logic [CIDX_W-1:0]       r_chain [NUM_CHUNKS];
    logic [CIDX_W-1:0]       n_chain [NUM_CHUNKS];
    logic [NUM_CHUNKS-1:0]   r_seen, n_seen;
    logic [CLEN_W-1:0]       r_len, n_len;
    logic [CLEN_W-1:0]       r_idx, n_idx;
    logic [CLEN_W-1:0]       r_i, n_i;
    logic [CIDX_W-1:0]       r_cur, n_cur;
    logic [CIDX_W-1:0]       r_tgt, n_tgt;
    logic [SIZE_W-1:0]       r_rem, n_rem;
    logic [SIZE_W-1:0]       r_rem0, n_rem0;
    logic [OFF_W-1:0]        r_pos, n_pos;
    logic [TOT_W-1:0]        r_acc, n_acc;
    logic                    r_sum, n_sum;

    // captured item and result
    logic [KIND_W-1:0]       r_kind, n_kind;
    logic [SIZE_W-1:0]       r_size, n_size;
    logic [DATA_W-1:0]       r_data, n_data;
    logic                    r_grow, n_grow;
    logic [STATUS_W-1:0]     r_status, n_status;
    logic [HEAD_W-1:0]       r_rhead, n_rhead;
    logic [DATA_W-1:0]       r_rbyte, n_rbyte;
    logic [CNT_W-1:0]        r_total, n_total;
    logic [CNT_W-1:0]        r_filled, n_filled;

    // link memory and byte memory
    logic [CIDX_W-1:0]       succ_mem [NUM_CHUNKS];
    logic [CIDX_W-1:0]       succ_rd;
    logic                    succ_we, succ_re;
    logic [CIDX_W-1:0]       succ_waddr, succ_wdata, succ_raddr;
    logic [DATA_W-1:0]       byte_mem [BYTE_DEPTH];
    logic [DATA_W-1:0]       byte_rd;
    logic                    byte_we, byte_re;
    logic [BADDR_W-1:0]      byte_waddr, byte_raddr;
    logic [DATA_W-1:0]       byte_wdata;

    // helpers
    logic [CLEN_W-1:0]       lim;
    logic [FILL_W-1:0]       cb;
    logic [CIDX_W-1:0]       fill_addr;
    logic [FILL_W-1:0]       fill_rd;
    logic [CIDX_W-1:0]       chain_at_idx;
    logic [CIDX_W-1:0]       tail;
    logic [CIDX_W-1:0]       scan_idx;
    logic [SIZE_W-1:0]       rem_next;
    logic [TOT_W-1:0]        cur_total;
    logic [TOT_W-1:0]        size_ext;
    logic [CLEN_W-1:0]       len_inc;

    // effective register values, clamped to the pool geometry
    always_comb begin
        if (r_cfg_count == '0) begin
            lim = CLEN_W'(1);
        end else if (int'(r_cfg_count) > NUM_CHUNKS) begin
            lim = CLEN_W'(NUM_CHUNKS);
        end else begin
            lim = CLEN_W'(r_cfg_count);
        end
        if (r_cfg_bytes == '0) begin
            cb = FILL_W'(1);
        end else if (int'(r_cfg_bytes) > CHUNK_BYTES) begin
            cb = FILL_W'(CHUNK_BYTES);
        end else begin
            cb = FILL_W'(r_cfg_bytes);
        end
    end

    // shared lookups
    assign chain_at_idx = r_chain[CIDX_W'(r_idx)];
    assign tail         = r_chain[CIDX_W'(r_len - CLEN_W'(1))];
    assign scan_idx     = CIDX_W'(r_i);
    assign rem_next     = (r_rem <= SIZE_W'(cb)) ? '0 : r_rem - SIZE_W'(cb);
    assign cur_total    = TOT_W'(r_len) * TOT_W'(cb);
    assign size_ext     = TOT_W'(r_size);
    assign len_inc      = r_len + CLEN_W'(1);

    always_comb begin
        unique case (r_state)
            S_WALK:  fill_addr = r_cur;
            S_APWR:  fill_addr = r_tgt;
            default: fill_addr = chain_at_idx;
        endcase
    end
    assign fill_rd = r_fill[fill_addr];

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_in_use    = r_in_use;
        n_has_succ  = r_has_succ;
        n_fill      = r_fill;
        n_pred      = r_pred;
        n_chain     = r_chain;
        n_seen      = r_seen;
        n_len       = r_len;
        n_idx       = r_idx;
        n_i         = r_i;
        n_cur       = r_cur;
        n_tgt       = r_tgt;
        n_rem       = r_rem;
        n_rem0      = r_rem0;
        n_pos       = r_pos;
        n_acc       = r_acc;
        n_sum       = r_sum;
        n_kind      = r_kind;
        n_size      = r_size;
        n_data      = r_data;
        n_grow      = r_grow;
        n_status    = r_status;
        n_rhead     = r_rhead;
        n_rbyte     = r_rbyte;
        n_total     = r_total;
        n_filled    = r_filled;
        succ_we     = 1'b0;
        succ_waddr  = tail;
        succ_wdata  = scan_idx;
        succ_re     = 1'b0;
        succ_raddr  = r_cur;
        byte_we     = 1'b0;
        byte_waddr  = {r_tgt, fill_rd[OFS_W-1:0]};
        byte_wdata  = r_data;
        byte_re     = 1'b0;
        byte_raddr  = {chain_at_idx, r_pos[OFS_W-1:0]};

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && !r_out_valid) begin
                    n_kind   = i_in.item.kind;
                    n_size   = i_in.item.size_bytes;
                    n_pos    = i_in.item.byte_offset;
                    n_data   = i_in.item.data_byte;
                    n_grow   = i_in.item.grow;
                    n_rhead  = i_in.item.head;
                    n_status = ST_OK;
                    n_rbyte  = '0;
                    n_len    = '0;
                    n_i      = '0;
                    if (i_in.item.kind == KIND_ALLOC) begin
                        if (i_in.item.size_bytes == '0) begin
                            n_status = ST_RANGE;
                            n_state  = S_SUM;
                        end else begin
                            n_rem   = i_in.item.size_bytes;
                            n_rem0  = i_in.item.size_bytes;
                            n_state = S_CHECK;
                        end
                    end else if (i_in.item.kind > KIND_READ
                                 || int'(i_in.item.head) >= NUM_CHUNKS
                                 || !r_in_use[CIDX_W'(i_in.item.head)]
                                 || (i_in.item.kind == KIND_RESIZE
                                     && i_in.item.size_bytes == '0)) begin
                        n_status = ST_RANGE;
                        n_state  = S_SUM;
                    end else begin
                        n_cur   = CIDX_W'(i_in.item.head);
                        n_seen  = '0;
                        n_acc   = '0;
                        n_sum   = 1'b0;
                        n_state = S_WALK;
                    end
                end
            end

            // count free chunks until the request is covered
            S_CHECK: begin
                if (r_i == lim) begin
                    n_status = ST_NOFREE;
                    n_state  = S_SUM;
                end else begin
                    n_i = r_i + CLEN_W'(1);
                    if (!r_in_use[scan_idx]) begin
                        n_rem = rem_next;
                        if (rem_next == '0) begin
                            n_i     = '0;
                            n_rem   = r_rem0;
                            n_state = S_CLAIM;
                        end
                    end
                end
            end

            // take free chunks in ascending order and link them to the tail
            S_CLAIM: begin
                if (r_i == lim) begin
                    n_status = ST_NOFREE;
                    n_state  = S_SUM;
                end else begin
                    n_i = r_i + CLEN_W'(1);
                    if (!r_in_use[scan_idx]) begin
                        n_in_use[scan_idx]         = 1'b1;
                        n_has_succ[scan_idx]       = 1'b0;
                        n_fill[scan_idx]           = '0;
                        n_chain[CIDX_W'(r_len)]    = scan_idx;
                        n_len                      = len_inc;
                        n_tgt                      = scan_idx;
                        if (r_len == '0) begin
                            n_rhead = HEAD_W'(scan_idx);
                        end else begin
                            n_has_succ[tail]   = 1'b1;
                            succ_we            = 1'b1;
                            n_pred[scan_idx]   = tail;
                        end
                        n_rem = rem_next;
                        if (rem_next == '0) begin
                            case (r_kind)
                                KIND_APPEND: n_state = S_APWR;
                                KIND_WRITE: begin
                                    n_idx   = r_idx + CLEN_W'(1);
                                    n_state = S_WRSTEP;
                                end
                                default: n_state = S_SUM;
                            endcase
                        end
                    end
                end
            end

            // record one chunk of the walk, fetch its link
            S_WALK: begin
                n_chain[CIDX_W'(r_len)] = r_cur;
                n_seen[r_cur]           = 1'b1;
                n_acc                   = r_acc + TOT_W'(fill_rd);
                n_len                   = len_inc;
                if (int'(len_inc) == NUM_CHUNKS || !r_has_succ[r_cur]) begin
                    n_state = S_WDONE;
                end else begin
                    succ_re = 1'b1;
                    n_state = S_WWAIT;
                end
            end

            S_WWAIT: begin
                if (!r_in_use[succ_rd] || r_seen[succ_rd]) begin
                    n_state = S_WDONE;
                end else begin
                    n_cur   = succ_rd;
                    n_state = S_WALK;
                end
            end

            // walk finished: report totals or start the operation proper
            S_WDONE: begin
                if (r_sum) begin
                    n_total     = CNT_W'(cur_total);
                    n_filled    = CNT_W'(r_acc);
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end else begin
                    n_idx = '0;
                    case (r_kind)
                        KIND_RESIZE: begin
                            if (cur_total > size_ext) begin
                                n_rem   = SIZE_W'(cur_total - size_ext);
                                n_state = S_TRIM;
                            end else if (cur_total < size_ext) begin
                                n_rem   = SIZE_W'(size_ext - cur_total);
                                n_rem0  = SIZE_W'(size_ext - cur_total);
                                n_i     = '0;
                                n_state = S_CHECK;
                            end else begin
                                n_state = S_SUM;
                            end
                        end
                        KIND_FREE: begin
                            n_in_use   = r_in_use & ~r_seen;
                            n_has_succ = r_has_succ & ~r_seen;
                            for (int k = 0; k < NUM_CHUNKS; k++) begin
                                if (r_seen[k]) n_fill[k] = '0;
                            end
                            n_state = S_SUM;
                        end
                        KIND_APPEND: n_state = S_FINDF;
                        KIND_WRITE:  n_state = S_WRSTEP;
                        KIND_READ:   n_state = S_RDSTEP;
                        default:     n_state = S_SUM;
                    endcase
                end
            end

            // drop whole chunks from the tail
            S_TRIM: begin
                if (r_rem >= SIZE_W'(cb)) begin
                    n_in_use[tail]   = 1'b0;
                    n_has_succ[tail] = 1'b0;
                    n_fill[tail]     = '0;
                    n_len            = r_len - CLEN_W'(1);
                    n_rem            = r_rem - SIZE_W'(cb);
                end else begin
                    n_has_succ[tail] = 1'b0;
                    n_state          = S_SUM;
                end
            end

            // first chunk of the chain that is not full
            S_FINDF: begin
                if (r_idx >= r_len) begin
                    if (!r_grow) begin
                        n_status = ST_RANGE;
                        n_state  = S_SUM;
                    end else begin
                        n_rem   = SIZE_W'(1);
                        n_i     = '0;
                        n_state = S_CLAIM;
                    end
                end else if (fill_rd < cb) begin
                    n_tgt   = chain_at_idx;
                    n_state = S_APWR;
                end else begin
                    n_idx = r_idx + CLEN_W'(1);
                end
            end

            S_APWR: begin
                byte_we       = 1'b1;
                n_fill[r_tgt] = fill_rd + FILL_W'(1);
                n_state       = S_SUM;
            end

            // step along the chain toward the write position
            S_WRSTEP: begin
                if (r_pos < OFF_W'(cb)) begin
                    byte_we    = 1'b1;
                    byte_waddr = {chain_at_idx, r_pos[OFS_W-1:0]};
                    if (OFF_W'(fill_rd) < r_pos + OFF_W'(1)) begin
                        n_fill[chain_at_idx] = FILL_W'(r_pos + OFF_W'(1));
                    end
                    n_state = S_SUM;
                end else begin
                    n_fill[chain_at_idx] = cb;
                    n_pos                = r_pos - OFF_W'(cb);
                    if (r_idx + CLEN_W'(1) >= r_len) begin
                        if (!r_grow) begin
                            n_status = ST_RANGE;
                            n_state  = S_SUM;
                        end else begin
                            n_rem   = SIZE_W'(1);
                            n_i     = '0;
                            n_state = S_CLAIM;
                        end
                    end else begin
                        n_idx = r_idx + CLEN_W'(1);
                    end
                end
            end

            // step along the chain toward the read position
            S_RDSTEP: begin
                if (r_idx >= r_len) begin
                    n_status = ST_RANGE;
                    n_state  = S_SUM;
                end else if (r_pos >= OFF_W'(cb)) begin
                    n_pos = r_pos - OFF_W'(cb);
                    n_idx = r_idx + CLEN_W'(1);
                end else begin
                    byte_re = 1'b1;
                    n_state = S_RDWAIT;
                end
            end

            S_RDWAIT: begin
                n_rbyte = byte_rd;
                n_state = S_SUM;
            end

            // walk the result chain for its totals, or report zero totals for a free head
            S_SUM: begin
                if (!r_out_valid) begin
                    if (int'(r_rhead) < NUM_CHUNKS && r_in_use[CIDX_W'(r_rhead)]) begin
                        n_cur   = CIDX_W'(r_rhead);
                        n_len   = '0;
                        n_seen  = '0;
                        n_acc   = '0;
                        n_sum   = 1'b1;
                        n_state = S_WALK;
                    end else begin
                        n_total     = '0;
                        n_filled    = '0;
                        n_out_valid = 1'b1;
                        n_state     = S_IDLE;
                    end
                end
            end

            default: n_state = S_IDLE;
        endcase

        // result register drains independently of the sequencer
        if (r_out_valid && o_out.ready) n_out_valid = 1'b0;
    end

    // next item only once the previous result is taken
    assign i_in.ready = (r_state == S_IDLE) && !r_out_valid;

    // result item
    assign o_out.valid             = r_out_valid;
    assign o_out.item.status       = r_status;
    assign o_out.item.chain_head   = r_rhead;
    assign o_out.item.read_byte    = r_rbyte;
    assign o_out.item.total_bytes  = r_total;
    assign o_out.item.filled_bytes = r_filled;

    assign i_cfg.ready = 1'b1;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_in_use    <= '0;
            r_has_succ  <= '0;
            r_fill      <= '{default: '0};
            r_cfg_count <= CCOUNT_W'(NUM_CHUNKS);
            r_cfg_bytes <= CBYTES_W'(CHUNK_BYTES);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_in_use    <= n_in_use;
            r_has_succ  <= n_has_succ;
            r_fill      <= n_fill;
            if (i_cfg.valid) begin
                case (i_cfg.reg_index)
                    REG_CHUNK_COUNT: r_cfg_count <= i_cfg.wdata[CCOUNT_W-1:0];
                    REG_CHUNK_BYTES: r_cfg_bytes <= i_cfg.wdata;
                    default: ;
                endcase
            end
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_pred   <= n_pred;
        r_chain  <= n_chain;
        r_seen   <= n_seen;
        r_len    <= n_len;
        r_idx    <= n_idx;
        r_i      <= n_i;
        r_cur    <= n_cur;
        r_tgt    <= n_tgt;
        r_rem    <= n_rem;
        r_rem0   <= n_rem0;
        r_pos    <= n_pos;
        r_acc    <= n_acc;
        r_sum    <= n_sum;
        r_kind   <= n_kind;
        r_size   <= n_size;
        r_data   <= n_data;
        r_grow   <= n_grow;
        r_status <= n_status;
        r_rhead  <= n_rhead;
        r_rbyte  <= n_rbyte;
        r_total  <= n_total;
        r_filled <= n_filled;
    end

    // link memory
    always_ff @(posedge i_clk) begin
        if (succ_we) succ_mem[succ_waddr] <= succ_wdata;
        if (succ_re) succ_rd <= succ_mem[succ_raddr];
    end

    // byte memory
    always_ff @(posedge i_clk) begin
        if (byte_we) byte_mem[byte_waddr] <= byte_wdata;
        if (byte_re) byte_rd <= byte_mem[byte_raddr];
    end

    // an accepted item always leaves idle
    a_item_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state != S_IDLE))
        else $error("accepted item did not start work");

    // a good allocate reports a head that is in use
    a_alloc_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_kind == KIND_ALLOC && r_status == ST_OK)
            |-> r_in_use[CIDX_W'(r_rhead)])
        else $error("allocate returned a free head");

    // chain list never outgrows the pool
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (int'(r_len) <= NUM_CHUNKS))
        else $error("chain length beyond pool size");

endmodule

>>> tb/ccp_checker.sv
// ----------------------------------------------------------------------------
// ccp_checker
// Watches the operation, result and register channels of the chunk pool.
// Keeps its own copy of the pool (marks, links, fills, bytes) and predicts
// one result per accepted item, then compares results in order, field by field.
// ----------------------------------------------------------------------------
module ccp_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ccp_in_if    in_ch,
    ccp_out_if   out_ch,
    ccp_cfg_if   cfg_ch,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import ccp_pkg::*;

    // shadow pool state
    bit       in_use   [NUM_CHUNKS];
    bit       has_succ [NUM_CHUNKS];
    int       succ     [NUM_CHUNKS];
    int       fill     [NUM_CHUNKS];
    bit [7:0] bytes    [NUM_CHUNKS*CHUNK_BYTES];
    bit       written  [NUM_CHUNKS*CHUNK_BYTES];
    bit [CCOUNT_W-1:0] reg_count;
    bit [CBYTES_W-1:0] reg_bytes;

    // scratch chain from the latest walk
    int chain_buf [NUM_CHUNKS];
    int chain_len;

    t_out_item result_q[$];
    int        fails;

    assign o_fail_count = fails;
    assign o_pending    = result_q.size();

    function automatic int lim_count();
        if (reg_count < 1) return 1;
        if (reg_count > NUM_CHUNKS) return NUM_CHUNKS;
        return reg_count;
    endfunction

    function automatic int lim_bytes();
        if (reg_bytes < 1) return 1;
        if (reg_bytes > CHUNK_BYTES) return CHUNK_BYTES;
        return reg_bytes;
    endfunction

    // follow successor links, stop at a free or revisited chunk
    function automatic void walk_chain(int h);
        bit seen [NUM_CHUNKS];
        int cur;
        int nx;
        foreach (seen[k]) seen[k] = 0;
        cur = h;
        chain_len = 0;
        while (chain_len < NUM_CHUNKS) begin
            chain_buf[chain_len] = cur;
            chain_len++;
            seen[cur] = 1;
            if (!has_succ[cur]) break;
            nx = succ[cur];
            if (!in_use[nx] || seen[nx]) break;
            cur = nx;
        end
    endfunction

    function automatic int free_total();
        int n;
        n = 0;
        for (int i = 0; i < lim_count(); i++) if (!in_use[i]) n++;
        return n;
    endfunction

    function automatic int first_free();
        for (int i = 0; i < lim_count(); i++) if (!in_use[i]) return i;
        return NUM_CHUNKS;
    endfunction

    function automatic void claim(int n);
        in_use[n]   = 1;
        has_succ[n] = 0;
        fill[n]     = 0;
    endfunction

    function automatic void link_after(int tail, int n);
        claim(n);
        has_succ[tail] = 1;
        succ[tail]     = n;
    endfunction

    function automatic void release_chunk(int n);
        in_use[n]   = 0;
        has_succ[n] = 0;
        fill[n]     = 0;
    endfunction

    function automatic bit grow_chain();
        int n;
        n = first_free();
        if (n >= NUM_CHUNKS || chain_len >= NUM_CHUNKS) return 0;
        link_after(chain_buf[chain_len-1], n);
        chain_buf[chain_len] = n;
        chain_len++;
        return 1;
    endfunction

    function automatic void store_byte(int chunk, int pos, bit [7:0] d);
        bytes[chunk*CHUNK_BYTES + pos]   = d;
        written[chunk*CHUNK_BYTES + pos] = 1;
    endfunction

    // bytes spanned by the chain at h, zero when h is free
    function automatic int chain_total(int h);
        if (!in_use[h]) return 0;
        walk_chain(h);
        return chain_len * lim_bytes();
    endfunction

    // true unless a read at h/off would hit a byte never stored
    function automatic bit byte_known(int h, int off);
        int cb;
        int idx;
        cb = lim_bytes();
        if (!in_use[h]) return 1;
        walk_chain(h);
        idx = off / cb;
        if (idx >= chain_len) return 1;
        return written[chain_buf[idx]*CHUNK_BYTES + off % cb];
    endfunction

    // pool behavior for one operation item
    function automatic t_out_item pool_op(t_in_item it);
        t_out_item r;
        int cb, h, sz, off, need, first, tail, n, cur_total, drop, tgt, pos, idx;
        int total, filled;
        bit [1:0] st;
        int rhead;
        bit [7:0] rb;
        cb = lim_bytes();
        h = it.head;
        sz = it.size_bytes;
        off = it.byte_offset;
        st = ST_OK;
        rhead = h;
        rb = 0;
        if (it.kind == KIND_ALLOC) begin
            need = (sz + cb - 1) / cb;
            if (sz == 0) st = ST_RANGE;
            else if (free_total() < need) st = ST_NOFREE;
            else begin
                first = first_free();
                tail = first;
                claim(first);
                for (int i = 1; i < need; i++) begin
                    n = first_free();
                    link_after(tail, n);
                    tail = n;
                end
                rhead = first;
            end
        end else if (it.kind > KIND_READ || !in_use[h]) begin
            st = ST_RANGE;
        end else if (it.kind == KIND_RESIZE) begin
            walk_chain(h);
            cur_total = chain_len * cb;
            if (sz == 0) st = ST_RANGE;
            else if (cur_total > sz) begin
                drop = (cur_total - sz) / cb;
                for (int i = 0; i < drop; i++) release_chunk(chain_buf[chain_len-1-i]);
                has_succ[chain_buf[chain_len-1-drop]] = 0;
            end else if (cur_total < sz) begin
                need = (sz - cur_total + cb - 1) / cb;
                if (free_total() < need) st = ST_NOFREE;
                else for (int i = 0; i < need; i++) void'(grow_chain());
            end
        end else if (it.kind == KIND_FREE) begin
            walk_chain(h);
            for (int i = 0; i < chain_len; i++) release_chunk(chain_buf[i]);
        end else if (it.kind == KIND_APPEND) begin
            tgt = NUM_CHUNKS;
            walk_chain(h);
            for (int i = 0; i < chain_len; i++) begin
                if (fill[chain_buf[i]] < cb) begin
                    tgt = chain_buf[i];
                    break;
                end
            end
            if (tgt >= NUM_CHUNKS) begin
                if (!it.grow) st = ST_RANGE;
                else if (!grow_chain()) st = ST_NOFREE;
                else tgt = chain_buf[chain_len-1];
            end
            if (tgt < NUM_CHUNKS) begin
                store_byte(tgt, fill[tgt], it.data_byte);
                fill[tgt]++;
            end
        end else if (it.kind == KIND_WRITE) begin
            pos = off;
            idx = 0;
            walk_chain(h);
            forever begin
                n = chain_buf[idx];
                if (pos < cb) begin
                    store_byte(n, pos, it.data_byte);
                    if (fill[n] < pos + 1) fill[n] = pos + 1;
                    break;
                end
                // skipped chunk counts as full
                fill[n] = cb;
                pos -= cb;
                if (idx + 1 >= chain_len) begin
                    if (!it.grow) begin
                        st = ST_RANGE;
                        break;
                    end
                    if (!grow_chain()) begin
                        st = ST_NOFREE;
                        break;
                    end
                end
                idx++;
            end
        end else begin
            walk_chain(h);
            idx = off / cb;
            if (idx >= chain_len) st = ST_RANGE;
            else rb = bytes[chain_buf[idx]*CHUNK_BYTES + off % cb];
        end
        total = 0;
        filled = 0;
        if (in_use[rhead]) begin
            walk_chain(rhead);
            total = chain_len * cb;
            for (int i = 0; i < chain_len; i++) filled += fill[chain_buf[i]];
        end
        r.status       = st;
        r.chain_head   = rhead[HEAD_W-1:0];
        r.read_byte    = rb;
        r.total_bytes  = total[CNT_W-1:0];
        r.filled_bytes = filled[CNT_W-1:0];
        return r;
    endfunction

    task automatic report(string field, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
            fails++;
        end
    endtask

    // track registers and items, compare results
    always @(posedge i_clk) begin
        t_out_item exp_r;
        t_out_item act_r;
        if (!i_rst_n) begin
            foreach (in_use[k]) begin
                in_use[k] = 0;
                has_succ[k] = 0;
                succ[k] = 0;
                fill[k] = 0;
            end
            foreach (bytes[k]) begin
                bytes[k] = 0;
                written[k] = 0;
            end
            reg_count = 6'd32;
            reg_bytes = 7'd64;
            result_q.delete();
            fails = 0;
        end else begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                if (cfg_ch.reg_index == REG_CHUNK_COUNT) reg_count = cfg_ch.wdata[CCOUNT_W-1:0];
                else if (cfg_ch.reg_index == REG_CHUNK_BYTES) reg_bytes = cfg_ch.wdata;
            end
            if (in_ch.valid && in_ch.ready) result_q.push_back(pool_op(in_ch.item));
            if (out_ch.valid && out_ch.ready) begin
                act_r = out_ch.item;
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time, act_r);
                    fails++;
                end else begin
                    exp_r = result_q.pop_front();
                    report("status", exp_r.status, act_r.status);
                    report("chain_head", exp_r.chain_head, act_r.chain_head);
                    report("read_byte", exp_r.read_byte, act_r.read_byte);
                    report("total_bytes", exp_r.total_bytes, act_r.total_bytes);
                    report("filled_bytes", exp_r.filled_bytes, act_r.filled_bytes);
                end
            end
        end
    end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the chained chunk pool: directed operations on a fresh pool,
// then random phases under several register settings, with random idling on
// both channels. The checker predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ccp_pkg::*;

    logic clk;
    logic rst_n;
    bit   calm;
    int   fail_count;
    int   pending;

    ccp_in_if  in_ch ();
    ccp_out_if out_ch ();
    ccp_cfg_if cfg_ch ();

    chained_chunk_pool dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    ccp_checker chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .in_ch        (in_ch),
        .out_ch       (out_ch),
        .cfg_ch       (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // run limit
    initial begin
        #50_000_000;
        $display("chained_chunk_pool verification failed");
        $finish;
    end

    // result side stalls
    always @(posedge clk) begin
        if (!rst_n) out_ch.ready <= 1'b0;
        else out_ch.ready <= calm || ($urandom_range(0, 99) >= 6);
    end

    task automatic wait_drained();
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    // one register write while the pool is idle
    task automatic write_reg(t_reg_idx idx, int val);
        in_ch.valid <= 1'b0;
        wait_drained();
        repeat (10) @(posedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wdata     <= val[CFG_DATA_W-1:0];
        forever begin
            bit hs;
            @(negedge clk);
            hs = cfg_ch.ready;
            @(posedge clk);
            if (hs) break;
        end
        cfg_ch.valid <= 1'b0;
    endtask

    // send one item, reads only after the pool settles and hit stored bytes
    task automatic send_op(t_in_item it);
        int tot;
        if (it.kind == KIND_READ) begin
            in_ch.valid <= 1'b0;
            wait_drained();
            tot = chk.chain_total(it.head);
            for (int t = 0; t < 8 && !chk.byte_known(it.head, it.byte_offset); t++)
                it.byte_offset = OFF_W'($urandom_range(0, (tot > 0) ? tot - 1 : 0));
            if (!chk.byte_known(it.head, it.byte_offset)) it.kind = KIND_APPEND;
        end
        while (!calm && $urandom_range(0, 99) < 6) begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.item  <= it;
        forever begin
            bit hs;
            @(negedge clk);
            hs = in_ch.ready;
            @(posedge clk);
            if (hs) break;
        end
    endtask

    function automatic t_in_item mk_op(int kind, int head, int sz, int off, int d, bit g);
        t_in_item it;
        it.kind        = kind[KIND_W-1:0];
        it.head        = head[HEAD_W-1:0];
        it.size_bytes  = sz[SIZE_W-1:0];
        it.byte_offset = off[OFF_W-1:0];
        it.data_byte   = d[DATA_W-1:0];
        it.grow        = g;
        return it;
    endfunction

    // random in-use chunk most of the time, any chunk otherwise
    function automatic int pick_head();
        int live [$];
        for (int i = 0; i < NUM_CHUNKS; i++) if (chk.in_use[i]) live.push_back(i);
        if (live.size() == 0 || $urandom_range(0, 99) < 12)
            return $urandom_range(0, NUM_CHUNKS - 1);
        return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function automatic t_in_item rand_op(int cb);
        int r, kind, h, sz, off, tot;
        r = $urandom_range(0, 99);
        if (r < 22) kind = KIND_ALLOC;
        else if (r < 32) kind = KIND_RESIZE;
        else if (r < 41) kind = KIND_FREE;
        else if (r < 60) kind = KIND_APPEND;
        else if (r < 80) kind = KIND_WRITE;
        else if (r < 98) kind = KIND_READ;
        else kind = $urandom_range(6, 7);
        h = pick_head();
        r = $urandom_range(0, 99);
        if (r < 70) sz = $urandom_range(1, 3 * cb);
        else if (r < 90) sz = $urandom_range(1, 2048);
        else if (r < 95) sz = 0;
        else sz = $urandom_range(2049, 4095);
        tot = chk.chain_total(h);
        if ($urandom_range(0, 99) < 88) off = $urandom_range(0, tot + cb);
        else off = $urandom_range(0, 2047);
        if (off > 2047) off = 2047;
        return mk_op(kind, h, sz, off, $urandom, $urandom_range(0, 99) < 60);
    endfunction

    initial begin
        int counts [7] = '{32, 1, 32, 5, 0, 63, 17};
        int sizes  [7] = '{64, 1, 64, 7, 0, 127, 33};
        int cb;
        in_ch.valid      <= 1'b0;
        in_ch.item       <= '0;
        cfg_ch.valid     <= 1'b0;
        cfg_ch.reg_index <= REG_CHUNK_COUNT;
        cfg_ch.wdata     <= '0;
        rst_n            <= 1'b0;
        calm = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: fresh pool, chain at chunk 0 spanning two chunks
        send_op(mk_op(KIND_ALLOC, 0, 100, 0, 0, 0));
        send_op(mk_op(KIND_WRITE, 0, 0, 0, 8'hff, 0));
        send_op(mk_op(KIND_WRITE, 0, 0, 130, 8'h5a, 0));
        send_op(mk_op(KIND_WRITE, 0, 0, 130, 8'ha5, 1));
        send_op(mk_op(KIND_APPEND, 0, 0, 0, 8'h00, 0));
        send_op(mk_op(KIND_READ, 0, 0, 0, 0, 0));
        send_op(mk_op(KIND_READ, 0, 0, 130, 0, 0));
        send_op(mk_op(KIND_READ, 0, 0, 2047, 0, 0));
        send_op(mk_op(KIND_RESIZE, 0, 2048, 0, 0, 0));
        send_op(mk_op(KIND_RESIZE, 0, 1, 0, 0, 0));
        send_op(mk_op(KIND_RESIZE, 0, 0, 0, 0, 0));
        send_op(mk_op(KIND_APPEND, 0, 0, 0, 8'h11, 0));
        send_op(mk_op(KIND_FREE, 0, 0, 0, 0, 0));
        send_op(mk_op(KIND_FREE, 0, 0, 0, 0, 0));
        send_op(mk_op(KIND_APPEND, 31, 0, 0, 8'h22, 1));
        send_op(mk_op(KIND_READ, 31, 0, 0, 0, 0));
        send_op(mk_op(6, 0, 1, 0, 0, 1));
        send_op(mk_op(7, 31, 4095, 2047, 8'hff, 1));
        send_op(mk_op(KIND_ALLOC, 0, 0, 0, 0, 0));
        send_op(mk_op(KIND_ALLOC, 0, 4095, 0, 0, 0));
        send_op(mk_op(KIND_ALLOC, 0, 2048, 0, 0, 0));
        send_op(mk_op(KIND_WRITE, 0, 0, 2047, 8'h77, 1));
        send_op(mk_op(KIND_APPEND, 0, 0, 0, 8'h33, 1));
        send_op(mk_op(KIND_READ, 0, 0, 2047, 0, 0));
        send_op(mk_op(KIND_FREE, 0, 0, 0, 0, 0));

        // random phases over register settings
        for (int p = 0; p < 7; p++) begin
            write_reg(REG_CHUNK_COUNT, counts[p]);
            write_reg(REG_CHUNK_BYTES, sizes[p]);
            cb = (sizes[p] < 1) ? 1 : (sizes[p] > CHUNK_BYTES) ? CHUNK_BYTES : sizes[p];
            calm = (p == 2);
            for (int n = 0; n < 120; n++) send_op(rand_op(cb));
        end
        calm = 1'b0;
        in_ch.valid <= 1'b0;

        wait_drained();
        repeat (300) @(posedge clk);
        if (fail_count == 0) $display("chained_chunk_pool verification clean");
        else $display("chained_chunk_pool verification failed");
        $finish;
    end

endmodule
